>>> hdl/accel_self_test_checker_assert.svh
// Assertion macros for the accelerometer self-test checker.
// Both sample on aclk and are held off while aresetn is low.
`ifndef ACCEL_SELF_TEST_CHECKER_ASSERT_SVH
`define ACCEL_SELF_TEST_CHECKER_ASSERT_SVH

// Same-cycle implication.
`define ASTC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("accel self-test checker: same-cycle check failed");

// Next-cycle implication.
`define ASTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("accel self-test checker: next-cycle check failed");

`endif

>>> hdl/astc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astc_pkg
// Types and constants of the accelerometer self-test checker.
// ----------------------------------------------------------------------------
package astc_pkg;

    localparam int OPCODE_W = 2;
    localparam int ID_W     = 8;
    localparam int SAMPLE_W = 13;
    localparam int SHIFT_W  = 14;
    localparam int POLL_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int AXES     = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_POLL   = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        VERDICT_RUNNING  = 3'd0,
        VERDICT_PASS     = 3'd1,
        VERDICT_ID_ERROR = 3'd2,
        VERDICT_TIMEOUT  = 3'd3,
        VERDICT_WINDOW   = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_OFF  = 2'd1,
        PHASE_ON   = 2'd2
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPECTED_ID   = 3'd0,
        REG_TIMEOUT_LIMIT = 3'd1,
        REG_X_WIN_LOW     = 3'd2,
        REG_X_WIN_HIGH    = 3'd3,
        REG_Y_WIN_LOW     = 3'd4,
        REG_Y_WIN_HIGH    = 3'd5,
        REG_Z_WIN_LOW     = 3'd6,
        REG_Z_WIN_HIGH    = 3'd7
    } cfg_index_t;

    localparam logic [POLL_W-1:0] POLL_MAX = 24'hFF_FFFF;

    localparam logic [ID_W-1:0]          RST_EXPECTED_ID   = 8'd229;
    localparam logic [POLL_W-1:0]        RST_TIMEOUT_LIMIT = 24'h0F_FFFF;
    localparam logic signed [SHIFT_W-1:0] RST_X_WIN_LOW    = 14'sd89;
    localparam logic signed [SHIFT_W-1:0] RST_X_WIN_HIGH   = 14'sd956;
    localparam logic signed [SHIFT_W-1:0] RST_Y_WIN_LOW    = -14'sd956;
    localparam logic signed [SHIFT_W-1:0] RST_Y_WIN_HIGH   = -14'sd89;
    localparam logic signed [SHIFT_W-1:0] RST_Z_WIN_LOW    = 14'sd133;
    localparam logic signed [SHIFT_W-1:0] RST_Z_WIN_HIGH   = 14'sd1549;

endpackage

>>> hdl/accel_self_test_checker.sv
// A request passes the input register and then the result register on its way to the result.
// Throughput: one request per cycle; the only hold-off is a stalled result register.
// The final request of a run divides by a reciprocal multiply in the same stage.
// Reset (synchronous, aresetn low) restores the register defaults, clears the
// pipeline valids and returns the test to idle with all counts and sums zero.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_self_test_checker
// Three-axis accelerometer self-test: ID check, off/on sample sums, poll
// timeout, averaged shift per axis and window verdict.
// ----------------------------------------------------------------------------
module accel_self_test_checker #(
    parameter int SAMPLES_PER_PHASE = 10
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_wr_en,
    input  logic [astc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [astc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // request channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [astc_pkg::OPCODE_W-1:0]          s_opcode,
    input  logic [astc_pkg::ID_W-1:0]              s_device_id,
    input  logic signed [astc_pkg::SAMPLE_W-1:0]   s_sample_x,
    input  logic signed [astc_pkg::SAMPLE_W-1:0]   s_sample_y,
    input  logic signed [astc_pkg::SAMPLE_W-1:0]   s_sample_z,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_finished,
    output astc_pkg::verdict_t                     m_verdict,
    output logic                                   m_self_test_request,
    output logic signed [astc_pkg::SHIFT_W-1:0]    m_shift_x,
    output logic signed [astc_pkg::SHIFT_W-1:0]    m_shift_y,
    output logic signed [astc_pkg::SHIFT_W-1:0]    m_shift_z
);
    import astc_pkg::*;

    localparam int CNT_W  = $clog2(SAMPLES_PER_PHASE + 1);
    localparam int MAG_W  = SAMPLE_W + $clog2(2 * SAMPLES_PER_PHASE);
    localparam int DIFF_W = MAG_W + 1;
    localparam int QW     = MAG_W + 1;
    localparam int SH     = MAG_W + $clog2(SAMPLES_PER_PHASE);
    localparam int PROD_W = MAG_W + SH + 1;
    localparam longint unsigned RECIP_L =
        ((longint'(1) << SH) + SAMPLES_PER_PHASE - 1) / SAMPLES_PER_PHASE;
    localparam logic [SH:0]      RECIP    = RECIP_L[SH:0];
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_PHASE - 1);

    // configuration registers
    logic [ID_W-1:0]             expected_id_reg;
    logic [POLL_W-1:0]           timeout_limit_reg;
    logic signed [SHIFT_W-1:0]   win_low_reg  [AXES];
    logic signed [SHIFT_W-1:0]   win_high_reg [AXES];

    // input stage
    logic                        in_valid_reg;
    opcode_t                     opcode_reg;
    logic [ID_W-1:0]             device_id_reg;
    logic signed [SAMPLE_W-1:0]  sample_reg [AXES];

    // test state
    phase_t                      phase_reg, phase_next;
    logic [CNT_W-1:0]            sample_count_reg, sample_count_next;
    logic [POLL_W-1:0]           poll_count_reg, poll_count_next;
    logic signed [DIFF_W-1:0]    diff_reg [AXES];
    logic signed [DIFF_W-1:0]    diff_next [AXES];

    // result stage
    logic                        out_valid_reg;
    logic                        finished_reg, finished_next;
    verdict_t                    verdict_reg, verdict_next;
    logic                        request_reg;
    logic signed [SHIFT_W-1:0]   shift_reg  [AXES];
    logic signed [SHIFT_W-1:0]   shift_next [AXES];

    // datapath
    logic                        advance;
    logic                        proc_en;
    logic                        id_match;
    logic                        timed_out;
    logic                        last_sample;
    logic                        window_ok;
    logic signed [DIFF_W-1:0]    sample_ext [AXES];
    logic signed [DIFF_W-1:0]    diff_sum   [AXES];
    logic signed [DIFF_W-1:0]    diff_neg   [AXES];
    logic [MAG_W-1:0]            diff_mag   [AXES];
    logic [PROD_W-1:0]           prod       [AXES];
    logic [MAG_W-1:0]            quot       [AXES];
    logic signed [QW-1:0]        avg        [AXES];
    logic signed [QW-1:0]        lo_ext     [AXES];
    logic signed [QW-1:0]        hi_ext     [AXES];

    assign advance = !out_valid_reg || m_ready;
    assign proc_en = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_id_reg   <= RST_EXPECTED_ID;
            timeout_limit_reg <= RST_TIMEOUT_LIMIT;
            win_low_reg[0]    <= RST_X_WIN_LOW;
            win_high_reg[0]   <= RST_X_WIN_HIGH;
            win_low_reg[1]    <= RST_Y_WIN_LOW;
            win_high_reg[1]   <= RST_Y_WIN_HIGH;
            win_low_reg[2]    <= RST_Z_WIN_LOW;
            win_high_reg[2]   <= RST_Z_WIN_HIGH;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_EXPECTED_ID:   expected_id_reg   <= cfg_wdata[ID_W-1:0];
                REG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_wdata[POLL_W-1:0];
                REG_X_WIN_LOW:     win_low_reg[0]    <= cfg_wdata[SHIFT_W-1:0];
                REG_X_WIN_HIGH:    win_high_reg[0]   <= cfg_wdata[SHIFT_W-1:0];
                REG_Y_WIN_LOW:     win_low_reg[1]    <= cfg_wdata[SHIFT_W-1:0];
                REG_Y_WIN_HIGH:    win_high_reg[1]   <= cfg_wdata[SHIFT_W-1:0];
                REG_Z_WIN_LOW:     win_low_reg[2]    <= cfg_wdata[SHIFT_W-1:0];
                REG_Z_WIN_HIGH:    win_high_reg[2]   <= cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            opcode_reg    <= opcode_t'(s_opcode);
            device_id_reg <= s_device_id;
            sample_reg[0] <= s_sample_x;
            sample_reg[1] <= s_sample_y;
            sample_reg[2] <= s_sample_z;
        end
    end

    // ---------------- shared conditions and averaging ----------------
    assign id_match    = (device_id_reg == expected_id_reg);
    assign timed_out   = (poll_count_reg > timeout_limit_reg);
    assign last_sample = (sample_count_reg == CNT_LAST);

    // running difference sum_on - sum_off; divide by a reciprocal multiply
    always_comb begin
        for (int j = 0; j < AXES; j++) begin
            sample_ext[j] = DIFF_W'(sample_reg[j]);
            diff_sum[j]   = (phase_reg == PHASE_ON) ? diff_reg[j] + sample_ext[j]
                                                    : diff_reg[j] - sample_ext[j];
            diff_neg[j]   = -diff_sum[j];
            diff_mag[j]   = diff_sum[j][DIFF_W-1] ? diff_neg[j][MAG_W-1:0]
                                                  : diff_sum[j][MAG_W-1:0];
            prod[j]       = PROD_W'(diff_mag[j]) * PROD_W'(RECIP);
            quot[j]       = prod[j][SH +: MAG_W];
            avg[j]        = diff_sum[j][DIFF_W-1] ? -signed'({1'b0, quot[j]})
                                                  : signed'({1'b0, quot[j]});
            lo_ext[j]     = QW'(win_low_reg[j]);
            hi_ext[j]     = QW'(win_high_reg[j]);
        end
        window_ok = 1'b1;
        for (int j = 0; j < AXES; j++) begin
            if (avg[j] < lo_ext[j] || avg[j] > hi_ext[j]) begin
                window_ok = 1'b0;
            end
        end
    end

    // ---------------- phase: next state ----------------
    always_comb begin
        phase_next = phase_reg;
        unique case (opcode_reg) inside
            OP_START: begin
                phase_next = id_match ? PHASE_OFF : PHASE_IDLE;
            end
            OP_SAMPLE, OP_POLL: begin
                if (phase_reg != PHASE_IDLE) begin
                    if (timed_out) begin
                        phase_next = PHASE_IDLE;
                    end else if (opcode_reg == OP_SAMPLE && last_sample) begin
                        phase_next = (phase_reg == PHASE_OFF) ? PHASE_ON : PHASE_IDLE;
                    end
                end
            end
            default: ;
        endcase
    end

    // ---------------- counters, sums and result ----------------
    always_comb begin
        sample_count_next = sample_count_reg;
        poll_count_next   = poll_count_reg;
        finished_next     = 1'b0;
        verdict_next      = VERDICT_RUNNING;
        for (int j = 0; j < AXES; j++) begin
            diff_next[j]  = diff_reg[j];
            shift_next[j] = '0;
        end
        unique case (opcode_reg) inside
            OP_START: begin
                sample_count_next = '0;
                poll_count_next   = '0;
                for (int j = 0; j < AXES; j++) begin
                    diff_next[j] = '0;
                end
                if (!id_match) begin
                    finished_next = 1'b1;
                    verdict_next  = VERDICT_ID_ERROR;
                end
            end
            OP_SAMPLE, OP_POLL: begin
                if (phase_reg != PHASE_IDLE) begin
                    if (timed_out) begin
                        sample_count_next = '0;
                        poll_count_next   = '0;
                        for (int j = 0; j < AXES; j++) begin
                            diff_next[j] = '0;
                        end
                        finished_next = 1'b1;
                        verdict_next  = VERDICT_TIMEOUT;
                    end else if (opcode_reg == OP_POLL) begin
                        if (poll_count_reg != POLL_MAX) begin
                            poll_count_next = poll_count_reg + 1'b1;
                        end
                    end else begin
                        poll_count_next = '0;
                        for (int j = 0; j < AXES; j++) begin
                            diff_next[j] = diff_sum[j];
                        end
                        if (!last_sample) begin
                            sample_count_next = sample_count_reg + 1'b1;
                        end else begin
                            sample_count_next = '0;
                            if (phase_reg == PHASE_ON) begin
                                finished_next = 1'b1;
                                verdict_next  = window_ok ? VERDICT_PASS : VERDICT_WINDOW;
                                for (int j = 0; j < AXES; j++) begin
                                    diff_next[j]  = '0;
                                    shift_next[j] = avg[j][SHIFT_W-1:0];
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PHASE_IDLE;
            sample_count_reg <= '0;
            poll_count_reg   <= '0;
            for (int j = 0; j < AXES; j++) begin
                diff_reg[j] <= '0;
            end
        end else if (proc_en) begin
            phase_reg        <= phase_next;
            sample_count_reg <= sample_count_next;
            poll_count_reg   <= poll_count_next;
            for (int j = 0; j < AXES; j++) begin
                diff_reg[j] <= diff_next[j];
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_en) begin
            finished_reg <= finished_next;
            verdict_reg  <= verdict_next;
            request_reg  <= (phase_next == PHASE_ON);
            for (int j = 0; j < AXES; j++) begin
                shift_reg[j] <= shift_next[j];
            end
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_finished          = finished_reg;
    assign m_verdict           = verdict_reg;
    assign m_self_test_request = request_reg;
    assign m_shift_x           = shift_reg[0];
    assign m_shift_y           = shift_reg[1];
    assign m_shift_z           = shift_reg[2];

    // ---------------- assertions ----------------
`include "accel_self_test_checker_assert.svh"

    `ASTC_ASSERT_IMPLY(a_idle_counts_clear, phase_reg == PHASE_IDLE, sample_count_reg == '0 && poll_count_reg == '0)
    `ASTC_ASSERT_IMPLY(a_count_in_range, 1'b1, sample_count_reg <= CNT_LAST)
    `ASTC_ASSERT_IMPLY(a_request_only_running, m_valid && m_self_test_request, !m_finished && m_verdict == VERDICT_RUNNING)
    `ASTC_ASSERT_IMPLY(a_stall_blocks_input, in_valid_reg && out_valid_reg && !m_ready, !s_ready)
    `ASTC_ASSERT_NEXT(a_start_clears, proc_en && opcode_reg == OP_START, sample_count_reg == '0 && poll_count_reg == '0)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the accelerometer self-test checker. Requests go
// in through a queue-fed driver and results are scored against a cycle-free
// model of the test sequence: ID check, off/on sums, poll timeout and the
// per-axis window verdict. Several register settings are run, extremes among
// them, with random stalls on both channels in all but the last setting.
// ----------------------------------------------------------------------------
module tb_top;
    import astc_pkg::*;

    localparam int SAMPLES_PER_PHASE = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS = 70;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0]        op;
        logic [ID_W-1:0]            id;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } sensor_req_t;

    typedef struct packed {
        logic                       finished;
        verdict_t                   verdict;
        logic                       st_req;
        logic signed [SHIFT_W-1:0]  sx;
        logic signed [SHIFT_W-1:0]  sy;
        logic signed [SHIFT_W-1:0]  sz;
    } test_report_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    cfg_index_t                 cfg_index = REG_EXPECTED_ID;
    logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [OPCODE_W-1:0]        s_opcode = OP_START;
    logic [ID_W-1:0]            s_device_id = '0;
    logic signed [SAMPLE_W-1:0] s_sample_x = '0;
    logic signed [SAMPLE_W-1:0] s_sample_y = '0;
    logic signed [SAMPLE_W-1:0] s_sample_z = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_finished;
    verdict_t                   m_verdict;
    logic                       m_self_test_request;
    logic signed [SHIFT_W-1:0]  m_shift_x;
    logic signed [SHIFT_W-1:0]  m_shift_y;
    logic signed [SHIFT_W-1:0]  m_shift_z;

    // model of the checker
    phase_t             mdl_phase = PHASE_IDLE;
    int                 mdl_count = 0;
    logic [POLL_W-1:0]  mdl_polls = '0;
    int                 mdl_sum_off [AXES] = '{0, 0, 0};
    int                 mdl_sum_on [AXES] = '{0, 0, 0};
    logic [ID_W-1:0]    mdl_id = RST_EXPECTED_ID;
    logic [POLL_W-1:0]  mdl_timeout = RST_TIMEOUT_LIMIT;
    int mdl_lo [AXES] = '{int'(RST_X_WIN_LOW), int'(RST_Y_WIN_LOW), int'(RST_Z_WIN_LOW)};
    int mdl_hi [AXES] = '{int'(RST_X_WIN_HIGH), int'(RST_Y_WIN_HIGH), int'(RST_Z_WIN_HIGH)};

    // settings as the stimulus sees them
    logic [ID_W-1:0]    stim_id = RST_EXPECTED_ID;
    logic [POLL_W-1:0]  stim_tmo = RST_TIMEOUT_LIMIT;
    int stim_lo [AXES] = '{int'(RST_X_WIN_LOW), int'(RST_Y_WIN_LOW), int'(RST_Z_WIN_LOW)};
    int stim_hi [AXES] = '{int'(RST_X_WIN_HIGH), int'(RST_Y_WIN_HIGH), int'(RST_Z_WIN_HIGH)};

    sensor_req_t    sensor_requests [$];
    test_report_t   expected_reports [$];
    logic           req_taken = 1'b0;
    bit             quiet = 1'b0;
    int             send_gap = 0;
    int             send_calm = 0;
    int             take_gap = 0;
    int             take_calm = 0;
    int             mismatches = 0;
    int             cycles = 0;

    accel_self_test_checker #(
        .SAMPLES_PER_PHASE(SAMPLES_PER_PHASE)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_device_id(s_device_id),
        .s_sample_x(s_sample_x),
        .s_sample_y(s_sample_y),
        .s_sample_z(s_sample_z),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_finished(m_finished),
        .m_verdict(m_verdict),
        .m_self_test_request(m_self_test_request),
        .m_shift_x(m_shift_x),
        .m_shift_y(m_shift_y),
        .m_shift_z(m_shift_z)
    );

    initial forever #6 aclk = ~aclk;

    function automatic void clear_run_state();
        mdl_count = 0;
        mdl_polls = '0;
        mdl_sum_off = '{0, 0, 0};
        mdl_sum_on = '{0, 0, 0};
    endfunction

    function automatic test_report_t predict_self_test(input sensor_req_t rq);
        test_report_t rep;
        int reading [AXES];
        int shift [AXES];
        bit in_window;
        rep = '0;
        shift = '{0, 0, 0};
        reading[0] = int'($signed(rq.x));
        reading[1] = int'($signed(rq.y));
        reading[2] = int'($signed(rq.z));
        if (rq.op == OP_START) begin
            clear_run_state();
            if (rq.id != mdl_id) begin
                mdl_phase = PHASE_IDLE;
                rep.finished = 1'b1;
                rep.verdict = VERDICT_ID_ERROR;
            end else begin
                mdl_phase = PHASE_OFF;
            end
        end else if ((rq.op == OP_SAMPLE || rq.op == OP_POLL) && mdl_phase != PHASE_IDLE) begin
            if (mdl_polls > mdl_timeout) begin
                mdl_phase = PHASE_IDLE;
                clear_run_state();
                rep.finished = 1'b1;
                rep.verdict = VERDICT_TIMEOUT;
            end else if (rq.op == OP_POLL) begin
                if (mdl_polls != POLL_MAX)
                    mdl_polls++;
            end else begin
                mdl_polls = '0;
                for (int a = 0; a < AXES; a++) begin
                    if (mdl_phase == PHASE_OFF)
                        mdl_sum_off[a] += reading[a];
                    else
                        mdl_sum_on[a] += reading[a];
                end
                mdl_count++;
                if (mdl_count >= SAMPLES_PER_PHASE) begin
                    mdl_count = 0;
                    if (mdl_phase == PHASE_OFF) begin
                        mdl_phase = PHASE_ON;
                    end else begin
                        in_window = 1'b1;
                        for (int a = 0; a < AXES; a++) begin
                            // integer division truncates toward zero
                            shift[a] = (mdl_sum_on[a] - mdl_sum_off[a]) / SAMPLES_PER_PHASE;
                            if (shift[a] < mdl_lo[a] || shift[a] > mdl_hi[a])
                                in_window = 1'b0;
                        end
                        rep.finished = 1'b1;
                        rep.verdict = in_window ? VERDICT_PASS : VERDICT_WINDOW;
                        mdl_phase = PHASE_IDLE;
                        clear_run_state();
                    end
                end
            end
        end
        rep.st_req = (mdl_phase == PHASE_ON);
        rep.sx = SHIFT_W'(shift[0]);
        rep.sy = SHIFT_W'(shift[1]);
        rep.sz = SHIFT_W'(shift[2]);
        return rep;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        test_report_t want;
        sensor_req_t seen;
        int k;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_EXPECTED_ID: mdl_id = cfg_wdata[ID_W-1:0];
                    REG_TIMEOUT_LIMIT: mdl_timeout = cfg_wdata[POLL_W-1:0];
                    default: begin
                        k = cfg_index - REG_X_WIN_LOW;
                        if (k % 2 == 1)
                            mdl_hi[k / 2] = int'($signed(cfg_wdata[SHIFT_W-1:0]));
                        else
                            mdl_lo[k / 2] = int'($signed(cfg_wdata[SHIFT_W-1:0]));
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual verdict %0d %s",
                             $time, m_verdict, "with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("finished", int'(want.finished), int'(m_finished));
                    check_field("verdict", int'(want.verdict), int'(m_verdict));
                    check_field("self_test_request", int'(want.st_req),
                                int'(m_self_test_request));
                    check_field("shift_x", int'(want.sx), int'(m_shift_x));
                    check_field("shift_y", int'(want.sy), int'(m_shift_y));
                    check_field("shift_z", int'(want.sz), int'(m_shift_z));
                end
            end
            if (s_valid && s_ready) begin
                seen = {s_opcode, s_device_id, s_sample_x, s_sample_y, s_sample_z};
                expected_reports.push_back(predict_self_test(seen));
            end
        end
        req_taken <= aresetn && s_valid && s_ready;
    end

    always @(negedge aclk) begin : request_driver
        sensor_req_t nxt;
        if (aresetn && !(s_valid && !req_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (sensor_requests.size() > 0) begin
                nxt = sensor_requests.pop_front();
                s_valid <= 1'b1;
                s_opcode <= nxt.op;
                s_device_id <= nxt.id;
                s_sample_x <= nxt.x;
                s_sample_y <= nxt.y;
                s_sample_z <= nxt.z;
                if (send_calm > 0)
                    send_calm--;
                else if (!quiet && $urandom_range(39) == 0)
                    send_calm = $urandom_range(60, 20);
                else if (!quiet && $urandom_range(3) == 0)
                    send_gap = $urandom_range(8, 1);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (take_gap > 0) begin
            take_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (take_calm > 0)
                take_calm--;
            else if (!quiet && $urandom_range(39) == 0)
                take_calm = $urandom_range(60, 20);
            else if (!quiet && $urandom_range(3) == 0)
                take_gap = $urandom_range(8, 1);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic queue_request(input logic [OPCODE_W-1:0] op, input int id,
                                 input int x, input int y, input int z);
        sensor_req_t rq;
        rq.op = op;
        rq.id = ID_W'(id);
        rq.x = SAMPLE_W'(x);
        rq.y = SAMPLE_W'(y);
        rq.z = SAMPLE_W'(z);
        sensor_requests.push_back(rq);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    task automatic apply_config(input logic [ID_W-1:0] id, input logic [POLL_W-1:0] limit);
        stim_id = id;
        stim_tmo = limit;
        write_reg(REG_EXPECTED_ID, CFG_DATA_W'(id));
        write_reg(REG_TIMEOUT_LIMIT, limit);
        for (int a = 0; a < AXES; a++) begin
            write_reg(cfg_index_t'(REG_X_WIN_LOW + 2 * a), CFG_DATA_W'(stim_lo[a]));
            write_reg(cfg_index_t'(REG_X_WIN_HIGH + 2 * a), CFG_DATA_W'(stim_hi[a]));
        end
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    task automatic randomise_windows();
        for (int a = 0; a < AXES; a++) begin
            stim_lo[a] = rand_between(-2000, 1000);
            stim_hi[a] = stim_lo[a] + rand_between(0, 1500);
        end
    endtask

    task automatic wait_idle();
        while (sensor_requests.size() != 0 || s_valid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one start request and a full set of off/on samples aimed at a chosen shift,
    // with not-ready polls, stray opcodes and the odd restart mixed in
    task automatic queue_run(output int count);
        int shift_aim [AXES];
        int off_reading [SAMPLES_PER_PHASE][AXES];
        int on_row [AXES];
        int pick, lo_off, hi_off, cap, v;
        logic [ID_W-1:0] id;
        count = 0;
        cap = (stim_tmo < 4) ? int'(stim_tmo) + 2 : 3;
        id = ($urandom_range(9) == 0) ? stim_id ^ ID_W'($urandom_range(255, 1)) : stim_id;
        queue_request(OP_START, int'(id), rand_between(-4096, 4095), rand_between(-4096, 4095),
                      rand_between(-4096, 4095));
        count++;
        for (int a = 0; a < AXES; a++) begin
            pick = $urandom_range(9);
            if (pick < 6 && stim_lo[a] <= stim_hi[a])
                shift_aim[a] = rand_between(stim_lo[a], stim_hi[a]);
            else if (pick < 8)
                shift_aim[a] = pick[0] ? stim_lo[a] : stim_hi[a];
            else
                shift_aim[a] = rand_between(-8191, 8191);
            if (shift_aim[a] > 8000)
                shift_aim[a] = 8000;
            if (shift_aim[a] < -8000)
                shift_aim[a] = -8000;
            lo_off = (shift_aim[a] < 0) ? -4096 - shift_aim[a] : -4096;
            hi_off = (shift_aim[a] > 0) ? 4095 - shift_aim[a] : 4095;
            for (int i = 0; i < SAMPLES_PER_PHASE; i++)
                off_reading[i][a] = rand_between(lo_off, hi_off);
        end
        for (int i = 0; i < 2 * SAMPLES_PER_PHASE; i++) begin
            if ($urandom_range(5) == 0) begin
                repeat ($urandom_range(cap, 1)) begin
                    queue_request(OP_POLL, $urandom_range(255), rand_between(-4096, 4095),
                                  rand_between(-4096, 4095), rand_between(-4096, 4095));
                    count++;
                end
            end
            if ($urandom_range(40) == 0)
                queue_request(OP_UNUSED, $urandom_range(255), rand_between(-4096, 4095),
                              rand_between(-4096, 4095), rand_between(-4096, 4095));
            if ($urandom_range(200) == 0) begin
                queue_request(OP_START, int'(stim_id), 0, 0, 0);
                count++;
            end
            if (i < SAMPLES_PER_PHASE) begin
                queue_request(OP_SAMPLE, $urandom_range(255), off_reading[i][0],
                              off_reading[i][1], off_reading[i][2]);
            end else begin
                for (int a = 0; a < AXES; a++) begin
                    v = off_reading[i - SAMPLES_PER_PHASE][a] + shift_aim[a]
                        + rand_between(-5, 5);
                    on_row[a] = (v > 4095) ? 4095 : ((v < -4096) ? -4096 : v);
                end
                queue_request(OP_SAMPLE, $urandom_range(255), on_row[0], on_row[1], on_row[2]);
            end
            count++;
        end
    endtask

    initial begin : stimulus
        int made;
        int got;
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed part at the reset settings
        queue_request(OP_SAMPLE, 0, 4095, -4096, 0);
        queue_request(OP_POLL, 255, -4096, 4095, -1);
        queue_request(OP_START, 0, 0, 0, 0);
        queue_request(OP_START, 255, -1, -1, -1);
        queue_request(OP_START, int'(RST_EXPECTED_ID), 0, 0, 0);
        queue_request(OP_POLL, 0, 0, 0, 0);
        queue_request(OP_START, int'(RST_EXPECTED_ID), 0, 0, 0);
        for (int i = 0; i < 2 * SAMPLES_PER_PHASE; i++) begin
            if (i == SAMPLES_PER_PHASE + 1)
                queue_request(OP_UNUSED, 255, -1, -1, -1);
            if (i < SAMPLES_PER_PHASE)
                queue_request(OP_SAMPLE, 170, -4096, 4095, 0);
            else
                queue_request(OP_SAMPLE, 85, 4095, -4096, -1);
        end
        wait_idle();

        for (int ph = 1; ph <= 5; ph++) begin
            case (ph)
                1: begin
                    stim_lo = '{-8192, -8192, -8192};
                    stim_hi = '{8191, 8191, 8191};
                    apply_config(8'h00, POLL_MAX);
                end
                2: begin
                    randomise_windows();
                    apply_config(8'hFF, '0);
                    // two polls in a row exceed a zero poll allowance
                    queue_request(OP_START, 255, 0, 0, 0);
                    queue_request(OP_POLL, 0, 0, 0, 0);
                    queue_request(OP_POLL, 0, 0, 0, 0);
                end
                3: begin
                    randomise_windows();
                    apply_config(ID_W'($urandom_range(255)), POLL_W'($urandom_range(3, 1)));
                end
                4: begin
                    randomise_windows();
                    apply_config(ID_W'($urandom_range(255)),
                                 POLL_W'($urandom_range(16777215, 1000)));
                end
                default: begin
                    stim_lo = '{int'(RST_X_WIN_LOW), int'(RST_Y_WIN_LOW), int'(RST_Z_WIN_LOW)};
                    stim_hi = '{int'(RST_X_WIN_HIGH), int'(RST_Y_WIN_HIGH),
                                int'(RST_Z_WIN_HIGH)};
                    apply_config(ID_W'($urandom_range(255)), RST_TIMEOUT_LIMIT);
                    quiet = 1'b1;
                end
            endcase
            made = 0;
            while (made < PHASE_ITEMS) begin
                if ($urandom_range(3) != 0) begin
                    queue_run(got);
                    made += got;
                end else begin
                    repeat ($urandom_range(4, 1)) begin
                        queue_request(OPCODE_W'($urandom_range(3)),
                                      ($urandom_range(1) == 0) ? int'(stim_id)
                                                               : $urandom_range(255),
                                      rand_between(-4096, 4095), rand_between(-4096, 4095),
                                      rand_between(-4096, 4095));
                        made++;
                    end
                end
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/astc_pkg.sv
hdl/accel_self_test_checker.sv
tb/tb_top.sv
